/* hw/rtl/bole_pkg.sv */
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants of the ordered list engine
// Operation codes, status codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

  localparam int DEPTH_DEF = 16;
  localparam logic [4:0] CAP_RESET = 5'd10;

  typedef enum logic [3:0] {
    OP_CLEAR     = 4'd0,
    OP_APPEND    = 4'd1,
    OP_PREPEND   = 4'd2,
    OP_INS_AT    = 4'd3,
    OP_INS_SORT  = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_REM_BACK  = 4'd6,
    OP_REM_FRONT = 4'd7,
    OP_REM_VAL   = 4'd8,
    OP_FIND      = 4'd9,
    OP_READ      = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/bole_if.sv */
// ----------------------------------------------------------------------------
// bole_if: request and result channels of the ordered list engine
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bole_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] value;
  logic [4:0]         position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface bole_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic [4:0]         found_index;
  logic               found;
  logic [4:0]         entry_total;
  logic               is_full;
  logic               is_empty;

  modport source (output valid, status, result_value, found_index, found,
                  entry_total, is_full, is_empty, input ready);
  modport sink   (input valid, status, result_value, found_index, found,
                  entry_total, is_full, is_empty, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bole_ram.sv */
// ----------------------------------------------------------------------------
// bole_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bounded_ordered_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_unit: bounded ordered list of signed values
// Entries live in one ram; a sequencer scans and shifts them one per cycle.
// ----------------------------------------------------------------------------
// Sequence: clear, errors and unused codes answer directly from idle; inserts
//   shift the entries from the insert point up, then write the value; removals
//   read the entry, then shift the later entries down; a read only reads the
//   entry; a value search first compares the entries in order.
// Requests: one at a time; next request taken once the result
//   is delivered.
// Reset: count cleared, capacity set to 10; list contents undefined.
`default_nettype none

module bounded_ordered_list_engine_unit
  import bole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data,
  bole_req_if.sink        in_req,
  bole_rsp_if.source      out_rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_INS  = 6'b000100,
    S_SHUP = 6'b001000,
    S_PUT  = 6'b010000,
    S_RDX  = 6'b100000
  } state_t;

  typedef enum logic [0:0] {
    D_IDLE = 1'b0,
    D_SHDN = 1'b1
  } dn_t;

  state_t             state_r, state_nxt;
  dn_t                dn_r, dn_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [4:0]         cap_r;
  action_t            op_r, op_nxt;
  logic [31:0]        val_r, val_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  status_t            status_r, status_nxt;
  logic [31:0]        rval_r, rval_nxt;
  logic [4:0]         fidx_r, fidx_nxt;
  logic               found_r, found_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rd_data;

  logic [XW-1:0]      cnt_x, pos_x, cap_x, effcap_x;
  logic               full, hit, accept;
  logic [CW-1:0]      k, cnt_m1;
  action_t            act;

  bole_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // capacity and fullness
  assign cnt_x    = XW'(count_r);
  assign pos_x    = XW'(in_req.position);
  assign cap_x    = XW'(cap_r);
  assign effcap_x = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
  assign full     = cnt_x >= effcap_x;
  assign cnt_m1   = count_r - CW'(1);
  assign k        = j_r - CW'(1);
  assign act      = action_t'(in_req.action);

  assign in_req.ready = (state_r == S_IDLE) && (dn_r == D_IDLE) && !ovalid_r;
  assign accept       = in_req.valid && in_req.ready;

  // scan compare: equality for search, not-smaller for sorted insert
  assign hit = (op_r == OP_INS_SORT) ? ($signed(val_r) <= $signed(rd_data))
                                     : (val_r == rd_data);

  // result channel
  assign out_rsp.valid        = ovalid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.result_value = rval_r;
  assign out_rsp.found_index  = fidx_r;
  assign out_rsp.found        = found_r;
  assign out_rsp.entry_total  = 5'(count_r);
  assign out_rsp.is_full      = full;
  assign out_rsp.is_empty     = (count_r == '0);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    dn_nxt     = dn_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    ptr_nxt    = ptr_r;
    j_nxt      = j_r;
    status_nxt = status_r;
    rval_nxt   = rval_r;
    fidx_nxt   = fidx_r;
    found_nxt  = found_r;
    ovalid_nxt = ovalid_r && !out_rsp.ready;
    we         = 1'b0;
    waddr      = '0;
    wdata      = rd_data;
    raddr      = '0;

    if (dn_r == D_SHDN) begin
      // shift down: entry at ptr moves to ptr-1
      we    = 1'b1;
      waddr = ptr_r - AW'(1);
      if (CW'(ptr_r) == cnt_m1) begin
        count_nxt  = cnt_m1;
        dn_nxt     = D_IDLE;
        ovalid_nxt = 1'b1;
      end else begin
        raddr   = ptr_r + AW'(1);
        ptr_nxt = ptr_r + AW'(1);
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_nxt     = act;
            val_nxt    = in_req.value;
            status_nxt = ST_OK;
            rval_nxt   = '0;
            fidx_nxt   = '0;
            found_nxt  = 1'b0;
            ovalid_nxt = 1'b1;
            case (act)
              OP_CLEAR: begin
                count_nxt = '0;
              end
              OP_APPEND, OP_PREPEND, OP_INS_AT, OP_INS_SORT: begin
                if (full) begin
                  status_nxt = ST_FULL;
                end else if (act == OP_INS_AT && pos_x > cnt_x) begin
                  status_nxt = ST_BADIDX;
                end else if (act == OP_INS_SORT && count_r != '0) begin
                  ovalid_nxt = 1'b0;
                  raddr      = '0;
                  j_nxt      = CW'(1);
                  state_nxt  = S_SCAN;
                end else begin
                  ovalid_nxt = 1'b0;
                  state_nxt  = S_INS;
                  if (act == OP_APPEND) begin
                    idx_nxt = AW'(count_r);
                  end else if (act == OP_INS_AT) begin
                    idx_nxt = pos_x[AW-1:0];
                  end else begin
                    idx_nxt = '0;
                  end
                end
              end
              OP_REM_AT, OP_REM_BACK, OP_REM_FRONT, OP_REM_VAL, OP_READ: begin
                if (count_r == '0) begin
                  status_nxt = ST_EMPTY;
                end else if ((act == OP_REM_AT || act == OP_READ) && pos_x >= cnt_x) begin
                  status_nxt = ST_BADIDX;
                end else if (act == OP_REM_VAL) begin
                  ovalid_nxt = 1'b0;
                  raddr      = '0;
                  j_nxt      = CW'(1);
                  state_nxt  = S_SCAN;
                end else begin
                  ovalid_nxt = 1'b0;
                  state_nxt  = S_RDX;
                  if (act == OP_REM_BACK) begin
                    idx_nxt = AW'(cnt_m1);
                  end else if (act == OP_REM_FRONT) begin
                    idx_nxt = '0;
                  end else begin
                    idx_nxt = pos_x[AW-1:0];
                  end
                  raddr = idx_nxt;
                end
              end
              OP_FIND: begin
                if (count_r != '0) begin
                  ovalid_nxt = 1'b0;
                  raddr      = '0;
                  j_nxt      = CW'(1);
                  state_nxt  = S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // one entry compared per cycle
        S_SCAN: begin
          if (hit || j_r == count_r) begin
            case (op_r)
              OP_FIND: begin
                fidx_nxt   = hit ? 5'(k) : 5'(count_r);
                found_nxt  = hit;
                ovalid_nxt = 1'b1;
                state_nxt  = S_IDLE;
              end
              OP_REM_VAL: begin
                if (hit) begin
                  idx_nxt   = AW'(k);
                  raddr     = AW'(k);
                  state_nxt = S_RDX;
                end else begin
                  status_nxt = ST_NOTFOUND;
                  ovalid_nxt = 1'b1;
                  state_nxt  = S_IDLE;
                end
              end
              default: begin
                idx_nxt   = hit ? AW'(k) : AW'(count_r);
                state_nxt = S_INS;
              end
            endcase
          end else begin
            raddr = j_r[AW-1:0];
            j_nxt = j_r + CW'(1);
          end
        end

        // open a slot at idx
        S_INS: begin
          if (CW'(idx_r) == count_r) begin
            state_nxt = S_PUT;
          end else begin
            raddr     = AW'(cnt_m1);
            ptr_nxt   = AW'(cnt_m1);
            state_nxt = S_SHUP;
          end
        end

        // shift up: entry at ptr moves to ptr+1
        S_SHUP: begin
          we    = 1'b1;
          waddr = ptr_r + AW'(1);
          if (ptr_r == idx_r) begin
            state_nxt = S_PUT;
          end else begin
            raddr   = ptr_r - AW'(1);
            ptr_nxt = ptr_r - AW'(1);
          end
        end

        S_PUT: begin
          we         = 1'b1;
          waddr      = idx_r;
          wdata      = val_r;
          count_nxt  = count_r + CW'(1);
          fidx_nxt   = 5'(idx_r);
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end

        // entry at idx read out, then removal shift if needed
        S_RDX: begin
          rval_nxt  = rd_data;
          fidx_nxt  = 5'(idx_r);
          state_nxt = S_IDLE;
          if (op_r == OP_READ) begin
            ovalid_nxt = 1'b1;
          end else if (CW'(idx_r) == cnt_m1) begin
            count_nxt  = cnt_m1;
            ovalid_nxt = 1'b1;
          end else begin
            raddr   = idx_r + AW'(1);
            ptr_nxt = idx_r + AW'(1);
            dn_nxt  = D_SHDN;
          end
        end

        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dn_r     <= D_IDLE;
      count_r  <= '0;
      cap_r    <= CAP_RESET;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dn_r     <= dn_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    ptr_r    <= ptr_nxt;
    j_r      <= j_nxt;
    status_r <= status_nxt;
    rval_r   <= rval_nxt;
    fidx_r   <= fidx_nxt;
    found_r  <= found_nxt;
  end

endmodule

`default_nettype wire

/* tb/bounded_ordered_list_engine_unit_test.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_unit_test: self-checking bench of the list engine
// Directed and random requests go through the request channel, while a
// scoreboard predicts each result from its own copy of the list. Both
// channels idle and stall in several phases. The capacity is swept across
// its extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_ordered_list_engine_unit_test;
  import bole_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;
  localparam logic [3:0] ACT_SPARE_LO = 4'd11;
  localparam logic [3:0] ACT_SPARE_HI = 4'd15;
  localparam int SETTLE_CYCLES = 48;
  localparam int PENDING_DEPTH = 64;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [4:0]         found_index;
    logic               found;
    logic [4:0]         entry_total;
    logic               is_full;
    logic               is_empty;
  } list_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_data;

  bole_req_if req_bus ();
  bole_rsp_if rsp_bus ();

  bounded_ordered_list_engine_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  // shadow list and capacity
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int                 shadow_count;
  int                 shadow_cap;

  // expected results in request order; each counter has one writer
  list_result_t       pending_results [PENDING_DEPTH];
  int                 pending_pushed = 0;
  int                 pending_popped = 0;

  int error_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_cycles;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // computes the result of one request and updates the shadow list
  function automatic void predict_list_request(logic [3:0] act, logic signed [31:0] v,
                                               logic [4:0] pos);
    list_result_t r;
    int           idx;
    int           eff_cap;
    bit           was_full;
    r = '0;
    r.status = ST_OK;
    eff_cap = (shadow_cap > LIST_DEPTH) ? LIST_DEPTH : shadow_cap;
    was_full = (shadow_count >= eff_cap);
    idx = 0;
    case (act)
      OP_CLEAR: shadow_count = 0;
      OP_APPEND, OP_PREPEND, OP_INS_AT, OP_INS_SORT: begin
        if (was_full) begin
          r.status = ST_FULL;
        end else if (act == OP_INS_AT && int'(pos) > shadow_count) begin
          r.status = ST_BADIDX;
        end else begin
          if (act == OP_APPEND) idx = shadow_count;
          else if (act == OP_INS_AT) idx = int'(pos);
          else if (act == OP_INS_SORT) begin
            while (idx < shadow_count && v > shadow_list[idx]) idx++;
          end
          for (int k = shadow_count; k > idx; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[idx] = v;
          shadow_count++;
          r.found_index = 5'(idx);
        end
      end
      OP_REM_AT, OP_REM_BACK, OP_REM_FRONT, OP_REM_VAL, OP_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (act == OP_REM_AT || act == OP_READ) idx = int'(pos);
          else if (act == OP_REM_BACK) idx = shadow_count - 1;
          else if (act == OP_REM_VAL) begin
            while (idx < shadow_count && shadow_list[idx] != v) idx++;
          end
          if (idx >= shadow_count) begin
            r.status = (act == OP_REM_VAL) ? ST_NOTFOUND : ST_BADIDX;
          end else begin
            r.result_value = shadow_list[idx];
            r.found_index = 5'(idx);
            if (act != OP_READ) begin
              shadow_count--;
              for (int k = idx; k < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
            end
          end
        end
      end
      OP_FIND: begin
        while (idx < shadow_count && shadow_list[idx] != v) idx++;
        r.found_index = 5'(idx);
        r.found = (idx < shadow_count);
      end
      default: ;
    endcase
    r.entry_total = 5'(shadow_count);
    r.is_full = (shadow_count >= eff_cap);
    r.is_empty = (shadow_count == 0);
    pending_results[6'(pending_pushed)] = r;
    pending_pushed++;
  endfunction

  // sends one request, optionally after some idle cycles
  task automatic send_request(logic [3:0] act, logic signed [31:0] v, logic [4:0] pos);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      req_bus.valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    req_bus.valid = 1'b1;
    req_bus.action = act;
    req_bus.value = v;
    req_bus.position = pos;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predict_list_request(act, v, pos);
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_pushed != pending_popped) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    wait_until_idle();
    cfg_we = 1'b1;
    cfg_data = cap;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_cap = int'(cap);
  endtask

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      rsp_bus.ready = 1'b0;
      hold_off_cycles--;
    end else begin
      rsp_bus.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    list_result_t exp_r;
    list_result_t got_r;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      got_r = '{rsp_bus.status, rsp_bus.result_value, rsp_bus.found_index, rsp_bus.found,
                rsp_bus.entry_total, rsp_bus.is_full, rsp_bus.is_empty};
      if (pending_pushed == pending_popped) begin
        $display("%0t: unexpected result %h", $time, got_r);
        error_count++;
      end else begin
        exp_r = pending_results[6'(pending_popped)];
        pending_popped++;
        if (got_r.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got_r.status);
          error_count++;
        end
        if (got_r.result_value !== exp_r.result_value) begin
          $display("%0t: result_value expected %0d actual %0d", $time,
                   exp_r.result_value, got_r.result_value);
          error_count++;
        end
        if (got_r.found_index !== exp_r.found_index) begin
          $display("%0t: found_index expected %0d actual %0d", $time,
                   exp_r.found_index, got_r.found_index);
          error_count++;
        end
        if (got_r.found !== exp_r.found) begin
          $display("%0t: found expected %0b actual %0b", $time, exp_r.found, got_r.found);
          error_count++;
        end
        if (got_r.entry_total !== exp_r.entry_total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time,
                   exp_r.entry_total, got_r.entry_total);
          error_count++;
        end
        if (got_r.is_full !== exp_r.is_full) begin
          $display("%0t: is_full expected %0b actual %0b", $time, exp_r.is_full, got_r.is_full);
          error_count++;
        end
        if (got_r.is_empty !== exp_r.is_empty) begin
          $display("%0t: is_empty expected %0b actual %0b", $time,
                   exp_r.is_empty, got_r.is_empty);
          error_count++;
        end
      end
    end
  end

  // random value, mostly from a small pool so that searches hit
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed(32'($urandom_range(0, 6))) - 32'sd3;
    if (sel == 6) return 32'sh8000_0000;
    if (sel == 7) return 32'sh7fff_ffff;
    return $signed($urandom());
  endfunction

  function automatic logic [4:0] pick_position();
    if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, shadow_count + 1));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [3:0] pick_action();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) return OP_CLEAR;
    if (sel < 4) return 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if (sel < 50) return 4'($urandom_range(OP_APPEND, OP_INS_SORT));
    return 4'($urandom_range(OP_REM_AT, OP_READ));
  endfunction

  task automatic test_directed();
    send_request(OP_CLEAR, 32'sd0, 5'd0);
    send_request(OP_READ, 32'sd0, 5'd0);
    send_request(OP_REM_BACK, 32'sd0, 5'd0);
    send_request(OP_REM_VAL, 32'sd5, 5'd0);
    send_request(OP_FIND, 32'sd5, 5'd0);
    send_request(OP_INS_AT, 32'sd9, 5'd1);
    send_request(OP_APPEND, 32'sh7fff_ffff, 5'd0);
    send_request(OP_PREPEND, 32'sh8000_0000, 5'd31);
    send_request(OP_INS_SORT, 32'sd7, 5'd0);
    send_request(OP_INS_SORT, 32'sh7fff_ffff, 5'd0);
    send_request(OP_INS_AT, -32'sd1, 5'd4);
    send_request(OP_FIND, 32'sd7, 5'd0);
    send_request(OP_FIND, 32'sd8, 5'd0);
    send_request(OP_READ, 32'sd0, 5'd5);
    send_request(OP_READ, 32'sd0, 5'd4);
    send_request(OP_REM_VAL, 32'sd8, 5'd0);
    send_request(OP_REM_VAL, 32'sh7fff_ffff, 5'd0);
    send_request(OP_REM_AT, 32'sd0, 5'd4);
    send_request(OP_REM_AT, 32'sd0, 5'd1);
    send_request(OP_REM_FRONT, 32'sd0, 5'd0);
    send_request(ACT_SPARE_LO, 32'sd1, 5'd1);
    send_request(ACT_SPARE_HI, -32'sd1, 5'd31);
    // list holds two entries; shrink capacity below the count
    write_capacity(5'd1);
    send_request(OP_APPEND, 32'sd1, 5'd0);
    send_request(OP_REM_BACK, 32'sd0, 5'd0);
    send_request(OP_INS_AT, 32'sd2, 5'd9);
  endtask

  task automatic test_random_phase(logic [4:0] cap, int idle_pct, int stall_pct, int n);
    write_capacity(cap);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) send_request(pick_action(), pick_value(), pick_position());
  endtask

  task automatic test_pressure();
    wait_until_idle();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 300;
    for (int k = 0; k < 12; k++) send_request(pick_action(), pick_value(), pick_position());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.action = '0;
    req_bus.value = '0;
    req_bus.position = '0;
    rsp_bus.ready = 1'b0;
    error_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    shadow_count = 0;
    shadow_cap = int'(CAP_RESET);
    foreach (shadow_list[k]) shadow_list[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(5'd16, 0, 0, 100);
    test_random_phase(5'd1, 50, 0, 60);
    test_random_phase(5'd31, 0, 50, 100);
    test_random_phase(5'd0, 32, 32, 40);
    test_random_phase(5'd5, 32, 32, 100);
    test_random_phase(5'd10, 0, 0, 80);
    test_random_phase(5'd16, 50, 50, 100);
    test_pressure();

    wait_until_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/bole_pkg.sv
hw/rtl/bole_if.sv
hw/rtl/bole_ram.sv
hw/rtl/bounded_ordered_list_engine_unit.sv
tb/bounded_ordered_list_engine_unit_test.sv
